// ===== rtl/mppf_pkg.sv =====
// Shared constants for the multichannel pulse pattern framer.
// No dependencies; used by mppf_div, the top level and the testbench.
`default_nettype none

package mppf_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_CHANNEL_COUNT = 16;
  localparam int DEF_SLOT_COUNT    = 100;

  // Fixed field widths
  localparam int CHAN_W  = 4;
  localparam int LEVEL_W = 8;
  localparam int FREQ_W  = 8;

  // Item opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Frequency codes with a fixed meaning
  localparam logic [FREQ_W-1:0] CODE_OFF       = 8'd0;
  localparam logic [FREQ_W-1:0] CODE_ALWAYS_ON = 8'd255;

  // Frame header bytes folded into the checksum
  localparam logic [LEVEL_W-1:0] FRAME_ADDRESS = 8'h2A;
  localparam logic [LEVEL_W-1:0] FRAME_COMMAND = 8'h56;
  localparam logic [LEVEL_W-1:0] FRAME_DEVICE  = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/mppf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
`default_nettype none

module mppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mppf_div.sv =====
// Restoring divider: constant dividend over an 8-bit divisor, one bit a cycle.
// Uses mppf_pkg for the divisor width.
`default_nettype none

module mppf_div #(
  parameter int DIVIDEND = 100,
  parameter int Q_W      = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mppf_pkg::FREQ_W-1:0] divisor,
  output logic                             done,
  output logic      [Q_W-1:0]              quotient
);

  localparam int IDX_W = (Q_W > 1) ? $clog2(Q_W) : 1;
  localparam logic [Q_W-1:0] DVD = Q_W'(DIVIDEND);

  logic                        busy;
  logic [IDX_W-1:0]            idx;
  logic [mppf_pkg::FREQ_W-1:0] dsr;
  logic [mppf_pkg::FREQ_W-1:0] rem;
  logic [mppf_pkg::FREQ_W:0]   trial;
  logic                        qbit;

  always_comb begin
    trial = {rem, DVD[idx]};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= IDX_W'(Q_W - 1);
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        quotient <= {quotient[Q_W-2:0], qbit};
        rem      <= qbit ? mppf_pkg::FREQ_W'(trial - {1'b0, dsr})
                         : trial[mppf_pkg::FREQ_W-1:0];
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multichannel_pulse_pattern_framer_top.sv =====
// Multichannel pulse pattern framer: top level with the refill and tick sequencer.
// Depends on mppf_pkg, mppf_ram (level table) and mppf_div (period divider).
//
// Usage
//   Input channel (in_valid / in_stall): one beat is either a tick (opcode 0) or
//   an update of one channel (opcode 1). in_stall is high whenever the sequencer
//   is busy; one item is worked on at a time.
//   Output channel (frame_valid / frame_stall): one frame beat per active channel
//   on each tick, ascending channel order, frame_last on the final one.
//   Update: a disable or an out-of-range channel is handled in S_IDLE. An enable with
//   code 0 or 255 fills the whole row in S_FILL; other codes first run the divider
//   (S_DIV), then write one slot a cycle for the pattern length, plus a closing
//   step with no write when a rewritten row's pattern stops short of its end; a
//   row never written since reset is written whole.
//   Tick: S_TRD for each inactive channel, S_TRD then S_TOUT for each active
//   one, S_TOUT waiting out frame_stall; the level table read port sets this.
//   The output register lets the next item be taken while the last frame waits.
// Reset clears the active flags, the row-written flags and the slot position;
// a row not written since reset reads as zero, so no clearing pass is needed.
// A stalled frame holds its payload until taken.
`default_nettype none

module multichannel_pulse_pattern_framer_top #(
  parameter int CHANNEL_COUNT = mppf_pkg::DEF_CHANNEL_COUNT,
  parameter int SLOT_COUNT    = mppf_pkg::DEF_SLOT_COUNT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // item channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         opcode,
  input  wire logic [mppf_pkg::CHAN_W-1:0]  channel_index,
  input  wire logic                         enable_flag,
  input  wire logic [mppf_pkg::FREQ_W-1:0]  frequency_code,
  input  wire logic [mppf_pkg::LEVEL_W-1:0] amp_high,
  input  wire logic [mppf_pkg::LEVEL_W-1:0] amp_low,
  // frame channel
  output logic                              frame_valid,
  input  wire logic                         frame_stall,
  output logic      [mppf_pkg::CHAN_W-1:0]  frame_channel,
  output logic      [mppf_pkg::LEVEL_W-1:0] frame_level,
  output logic      [mppf_pkg::LEVEL_W-1:0] frame_checksum,
  output logic                              frame_last
);

  localparam int CIDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int DEPTH  = CHANNEL_COUNT * (2 ** SLOT_W);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_CMP_W = mppf_pkg::CHAN_W + 1;

  localparam logic [CIDX_W-1:0] LAST_CH   = CIDX_W'(CHANNEL_COUNT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_TOUT = 3'd4;

  logic [2:0]                 state;
  logic [CHANNEL_COUNT-1:0]   en_bits;
  logic [CHANNEL_COUNT-1:0]   row_valid;
  logic [SLOT_W-1:0]          slot;
  logic [CIDX_W-1:0]          scan;

  // refill context
  logic [mppf_pkg::CHAN_W-1:0]  fill_ch;
  logic [mppf_pkg::LEVEL_W-1:0] fill_hi;
  logic [mppf_pkg::LEVEL_W-1:0] fill_lo;
  logic [mppf_pkg::LEVEL_W-1:0] fill_val;
  logic [mppf_pkg::FREQ_W-1:0]  fill_freq;
  logic                         fill_full;
  logic                         fill_fresh;
  logic [CNT_W-1:0]             period;
  logic [CNT_W-1:0]             high_cnt;
  logic [CNT_W-1:0]             j;
  logic [mppf_pkg::FREQ_W-1:0]  p;
  logic [SLOT_W-1:0]            pos;

  // handshake and decode
  logic accept;
  logic ch_ok;
  logic normal_code;
  logic out_free;

  // refill datapath
  logic                         in_pat;
  logic                         fill_we;
  logic [mppf_pkg::LEVEL_W-1:0] fill_wdata;

  // tick datapath
  logic                         rd_en;
  logic [mppf_pkg::LEVEL_W-1:0] rd_data;
  logic [mppf_pkg::LEVEL_W-1:0] tick_level;
  logic                         any_above;

  logic                         div_start;
  logic                         div_done;
  logic [CNT_W-1:0]             div_q;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !frame_valid || !frame_stall;
  assign ch_ok    = ({1'b0, channel_index} < CH_CMP_W'(CHANNEL_COUNT));
  assign normal_code = (frequency_code != mppf_pkg::CODE_OFF)
                    && (frequency_code != mppf_pkg::CODE_ALWAYS_ON);

  assign div_start = accept && (opcode == mppf_pkg::OP_UPDATE) && ch_ok
                  && enable_flag && normal_code;

  // Inside the pattern span while periods remain; past it only a fresh row
  // is written, with zeros, so a rewritten row's tail keeps its old levels.
  always_comb begin
    in_pat  = fill_full || ((p < fill_freq) && (period != '0));
    fill_we = (state == S_FILL) && (in_pat || fill_fresh);
    if (fill_full) begin
      fill_wdata = fill_val;
    end else if (in_pat) begin
      fill_wdata = (j < high_cnt) ? fill_hi : fill_lo;
    end else begin
      fill_wdata = '0;
    end
  end

  assign rd_en = (state == S_TRD) && en_bits[scan];
  assign tick_level = row_valid[scan] ? rd_data : '0;

  // any active channel above the one being framed
  always_comb begin
    any_above = 1'b0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (en_bits[i] && (CH_CMP_W'(i) > CH_CMP_W'(scan))) begin
        any_above = 1'b1;
      end
    end
  end

  mppf_ram #(
    .WIDTH (mppf_pkg::LEVEL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (fill_we),
    .waddr (ADDR_W'({fill_ch, pos})),
    .wdata (fill_wdata),
    .re    (rd_en),
    .raddr (ADDR_W'({mppf_pkg::CHAN_W'(scan), slot})),
    .rdata (rd_data)
  );

  mppf_div #(
    .DIVIDEND (SLOT_COUNT),
    .Q_W      (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (frequency_code),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      en_bits     <= '0;
      row_valid   <= '0;
      slot        <= '0;
      frame_valid <= 1'b0;
    end else begin
      // frame taken by the receiver
      if (frame_valid && !frame_stall) begin
        frame_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == mppf_pkg::OP_TICK) begin
              scan  <= '0;
              state <= S_TRD;
            end else if (ch_ok) begin
              en_bits[channel_index[CIDX_W-1:0]] <= enable_flag;
              if (enable_flag) begin
                row_valid[channel_index[CIDX_W-1:0]] <= 1'b1;
                fill_ch    <= channel_index;
                fill_hi    <= amp_high;
                fill_lo    <= amp_low;
                fill_freq  <= frequency_code;
                fill_full  <= !normal_code;
                fill_val   <= (frequency_code == mppf_pkg::CODE_OFF) ? '0 : amp_high;
                fill_fresh <= !row_valid[channel_index[CIDX_W-1:0]];
                j          <= '0;
                p          <= '0;
                pos        <= '0;
                state      <= normal_code ? S_DIV : S_FILL;
              end
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            period   <= div_q;
            high_cnt <= div_q >> 1;
            state    <= S_FILL;
          end
        end

        S_FILL: begin
          if (!(in_pat || fill_fresh) || (pos == LAST_SLOT)) begin
            state <= S_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
          if (in_pat && !fill_full) begin
            if (j == period - 1'b1) begin
              j <= '0;
              p <= p + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end

        S_TRD: begin
          if (en_bits[scan]) begin
            state <= S_TOUT;
          end else if (scan == LAST_CH) begin
            slot  <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end

        S_TOUT: begin
          if (out_free) begin
            frame_valid    <= 1'b1;
            frame_channel  <= mppf_pkg::CHAN_W'(scan);
            frame_level    <= tick_level;
            frame_checksum <= mppf_pkg::FRAME_ADDRESS ^ mppf_pkg::FRAME_COMMAND
                            ^ mppf_pkg::FRAME_DEVICE
                            ^ mppf_pkg::LEVEL_W'(scan) ^ tick_level;
            frame_last     <= !any_above;
            if (scan == LAST_CH) begin
              slot  <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
              state <= S_IDLE;
            end else begin
              scan  <= scan + 1'b1;
              state <= S_TRD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/multichannel_pulse_pattern_framer_top_test.sv =====
// Testbench for multichannel_pulse_pattern_framer_top: directed and random ticks and updates,
// with frames checked against a behavioural model of the level tables held in a scoreboard.
// Depends on mppf_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module multichannel_pulse_pattern_framer_top_test;
  import mppf_pkg::*;

  localparam int CH_COUNT     = DEF_CHANNEL_COUNT;
  localparam int SLOTS        = DEF_SLOT_COUNT;
  localparam int RANDOM_ITEMS = 330;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
  localparam int DRAIN_LIMIT  = 200000;
  localparam int SETTLE       = 200;   // idle cycles after the last frame

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] checksum;
    logic               last;
  } frame_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the level tables, active flags and slot
  // position, turns every accepted beat into the frames it should produce and
  // checks frames in order.
  // ---------------------------------------------------------------------------
  class framer_scoreboard;
    logic [LEVEL_W-1:0] row_level [CH_COUNT][SLOTS];
    bit                 chan_active [CH_COUNT];
    int                 slot_pos;
    frame_t             pending_frames [$];
    int                 errors;

    function new();
      foreach (row_level[c, s]) row_level[c][s] = '0;
      foreach (chan_active[c]) chan_active[c] = 1'b0;
      slot_pos = 0;
      errors   = 0;
    endfunction

    // Rewrite a channel's row from a frequency code. Codes with a zero period
    // write nothing; slots past code*period keep their old levels.
    function void refill_row(int ch, logic [FREQ_W-1:0] code,
                             logic [LEVEL_W-1:0] hi, logic [LEVEL_W-1:0] lo);
      int period;
      int high_len;
      int pos;
      if (code == CODE_OFF) begin
        for (int s = 0; s < SLOTS; s++) row_level[ch][s] = '0;
      end else if (code == CODE_ALWAYS_ON) begin
        for (int s = 0; s < SLOTS; s++) row_level[ch][s] = hi;
      end else begin
        period   = SLOTS / int'(code);
        high_len = SLOTS / (2 * int'(code));
        for (int p = 0; p < int'(code); p++) begin
          for (int j = 0; j < period; j++) begin
            pos = p * period + j;
            if (pos < SLOTS) row_level[ch][pos] = (j < high_len) ? hi : lo;
          end
        end
      end
    endfunction

    // One frame per active channel at the shared slot, then the slot moves on.
    function void emit_tick_frames();
      int     last_ch;
      frame_t f;
      last_ch = -1;
      for (int c = 0; c < CH_COUNT; c++) if (chan_active[c]) last_ch = c;
      for (int c = 0; c < CH_COUNT; c++) begin
        if (chan_active[c]) begin
          f.channel  = CHAN_W'(c);
          f.level    = row_level[c][slot_pos];
          f.checksum = FRAME_ADDRESS ^ FRAME_COMMAND ^ FRAME_DEVICE
                       ^ LEVEL_W'(c) ^ f.level;
          f.last     = (c == last_ch);
          pending_frames.push_back(f);
        end
      end
      slot_pos = (slot_pos + 1 >= SLOTS) ? 0 : slot_pos + 1;
    endfunction

    function void take_item(logic op, logic [CHAN_W-1:0] ch, logic en,
                            logic [FREQ_W-1:0] code,
                            logic [LEVEL_W-1:0] hi, logic [LEVEL_W-1:0] lo);
      if (op == OP_UPDATE) begin
        if (int'(ch) < CH_COUNT) begin
          chan_active[ch] = en;
          if (en) refill_row(int'(ch), code, hi, lo);
        end
      end else begin
        emit_tick_frames();
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: channel %0d level %0d", got.channel, got.level);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      if (got.channel !== want.channel) begin
        $error("frame_channel: expected %0d, got %0d", want.channel, got.channel);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("frame_level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
      if (got.checksum !== want.checksum) begin
        $error("frame_checksum: expected %0d, got %0d", want.checksum, got.checksum);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function void report_leftover();
      if (pending_frames.size() != 0) begin
        $error("%0d frames never arrived", pending_frames.size());
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                opcode         = OP_TICK;
  logic [CHAN_W-1:0]   channel_index  = '0;
  logic                enable_flag    = 1'b0;
  logic [FREQ_W-1:0]   frequency_code = '0;
  logic [LEVEL_W-1:0]  amp_high       = '0;
  logic [LEVEL_W-1:0]  amp_low        = '0;

  logic                frame_valid;
  logic                frame_stall    = 1'b0;
  logic [CHAN_W-1:0]   frame_channel;
  logic [LEVEL_W-1:0]  frame_level;
  logic [LEVEL_W-1:0]  frame_checksum;
  logic                frame_last;

  bit                  hold_frames = 1'b0;  // asks the receiver for one long hold-off

  framer_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_pulse_pattern_framer_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .channel_index  (channel_index),
    .enable_flag    (enable_flag),
    .frequency_code (frequency_code),
    .amp_high       (amp_high),
    .amp_low        (amp_low),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_channel  (frame_channel),
    .frame_level    (frame_level),
    .frame_checksum (frame_checksum),
    .frame_last     (frame_last)
  );

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Frequency code mix: the fixed codes, zero-period codes, long periods and
  // the ordinary range all turn up regularly.
  function automatic logic [FREQ_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return CODE_OFF;
    if (r < 16) return CODE_ALWAYS_ON;
    if (r < 28) return FREQ_W'($urandom_range(101, 254));
    if (r < 40) return FREQ_W'($urandom_range(1, 7));
    return FREQ_W'($urandom_range(1, 100));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, quiet stretches, one long hold-off on request.
  // Stall changes only at the falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    int cyc;
    int run;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_frames) begin
        hold_frames = 1'b0;
        frame_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ((cyc / 600) % 3 == 1) begin
        frame_stall <= 1'b0;                 // stretch with no back-pressure
      end else begin
        run = pick_gap();
        if (run == 0) begin
          frame_stall <= 1'b0;
        end else begin
          frame_stall <= 1'b1;
          repeat (run - 1) @(negedge clk);
        end
      end
    end
  end

  // Frames are taken at the rising edge when valid and not stalled
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall)
      sb.check_frame('{frame_channel, frame_level, frame_checksum, frame_last});
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. A beat is offered from a falling edge and held until taken;
  // valid is only lowered by a gap, so back-to-back beats keep it high.
  // ---------------------------------------------------------------------------
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic offer_beat(input logic op, input logic [CHAN_W-1:0] ch, input logic en,
                            input logic [FREQ_W-1:0] code,
                            input logic [LEVEL_W-1:0] hi, input logic [LEVEL_W-1:0] lo);
    idle_cycles(pick_gap());
    @(negedge clk);
    in_valid       <= 1'b1;
    opcode         <= op;
    channel_index  <= ch;
    enable_flag    <= en;
    frequency_code <= code;
    amp_high       <= hi;
    amp_low        <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(op, ch, en, code, hi, lo);
  endtask

  task automatic update_chan(input int ch, input logic en, input logic [FREQ_W-1:0] code,
                             input logic [LEVEL_W-1:0] hi, input logic [LEVEL_W-1:0] lo);
    offer_beat(OP_UPDATE, CHAN_W'(ch), en, code, hi, lo);
  endtask

  // Tick with junk in the fields it ignores
  task automatic tick_beat();
    offer_beat(OP_TICK, CHAN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               FREQ_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)),
               LEVEL_W'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: quiet tick with every ignored field at its top value
    offer_beat(OP_TICK, 4'hF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    update_chan(0,  1'b1, 8'd1,           8'hFF, 8'h00);  // one long pulse
    update_chan(15, 1'b1, CODE_ALWAYS_ON, 8'hA5, 8'h5A);  // constantly high
    update_chan(5,  1'b1, CODE_OFF,       8'hFF, 8'hFF);  // all zero
    update_chan(3,  1'b1, 8'd100,         8'h11, 8'hEE);  // period 1, no high time
    update_chan(2,  1'b1, 8'd50,          8'h80, 8'h01);  // alternating slots
    update_chan(7,  1'b1, 8'd1,           8'h77, 8'h70);
    update_chan(7,  1'b1, 8'd3,           8'h01, 8'h02);  // last slot keeps 0x70
    update_chan(9,  1'b1, 8'd101,         8'hFF, 8'hFF);  // zero period: active, untouched
    update_chan(0,  1'b1, 8'd254,         8'h00, 8'h00);  // zero period over a live row
    update_chan(4,  1'b1, 8'd7,           8'hFF, 8'h00);
    tick_beat();
    tick_beat();
    tick_beat();
    update_chan(5,  1'b0, 8'd1,           8'h3C, 8'hC3);  // disable only
    tick_beat();
    update_chan(5,  1'b1, 8'd200,         8'h3C, 8'hC3);  // back on with old row
    update_chan(1,  1'b1, 8'd51,          8'h55, 8'hAA);
    repeat (4) tick_beat();

    // Random: mostly ticks so the slot position wraps a few times
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) hold_frames = 1'b1;   // receiver holds off while we keep sending
      if ($urandom_range(0, 99) < 30)
        update_chan($urandom_range(0, CH_COUNT - 1), 1'($urandom_range(0, 99) < 80),
                    pick_code(), LEVEL_W'($urandom_range(0, 255)),
                    LEVEL_W'($urandom_range(0, 255)));
      else
        tick_beat();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then give the block time to show any extra frame
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    sb.report_leftover();

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
